### sv/gphm_pkg.sv
package gphm_pkg;

  localparam logic [63:0] FNV_OFFSET = 64'd1469598103934665603;
  localparam logic [63:0] FNV_PRIME  = 64'd1099511628211;
  localparam logic [7:0]  CTRL_EMPTY = 8'h80;
  localparam logic [6:0]  FP_MASK    = 7'h7f;
  localparam int unsigned GROUP_WIDTH = 16;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_INSERT = 1'b1;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CLEAR = 7'b0000010,
    S_HASH  = 7'b0000100,
    S_MUL   = 7'b0001000,
    S_RD    = 7'b0010000,
    S_CHK   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

endpackage

### sv/group_probed_hash_map_unit.sv
// Open-addressing hash map with 8-byte zero-terminated keys. A request is a
// lookup or insert. The key is hashed with FNV-1a 64, one byte at a time,
// through one shared 64x64 multiply split into three 32x32 partial products
// (formed in S_HASH, summed in S_MUL), for up to 8 bytes. The probe then
// visits one slot at a time (registered memory read, then compare) from
// the start slot, wrapping at the capacity; a lookup ends at a matching key,
// at the end of a 16-slot group that held an empty slot or after the whole
// capacity is probed, an insert at the first empty slot or, failing that,
// after the whole capacity (status full). in_tready is low throughout a
// request. After reset the control store is swept to empty, one slot a
// cycle, before the first request is accepted. capacity_log2 is clamped to
// [4, log2(SLOTS)]. One result is held in an output register on the out_
// side until taken; the next request is accepted and worked on meanwhile
// and only waits in its final cycle if the previous result is still held.
module group_probed_hash_map_unit #(
  parameter int SLOTS = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [3:0]   cfg_wdata,       // capacity_log2
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,        // [63:0] key, [127:64] value
  input  logic         in_tuser,        // action
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [79:0]  out_tdata        // [1:0] status, [65:2] value_out,
                                        // [76:66] entry_count, rest zero
);

  localparam int AW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [4:0] LG_MAX = 5'(AW);

  gphm_pkg::state_t state_r, state_nxt;

  logic [3:0]    cap_lg_r;
  logic          act_r;
  logic [63:0]   key_r, val_r, norm_r, h_r;
  logic [3:0]    byte_r;
  logic [AW-1:0] idx_r, mask_r, clr_r;
  logic [AW:0]   probed_r;
  logic          any_empty_r;
  logic [CW-1:0] cnt_r;
  logic [1:0]    st_r;
  logic [63:0]   vout_r;
  logic          ovalid_r;
  logic [79:0]   odata_r;
  logic [63:0]   plo_r, pmid_r;
  logic [31:0]   phi_r;

  logic [7:0]    ctrl_rd;
  logic [63:0]   key_rd, val_rd;
  logic          ctrl_we, kv_we;
  logic [AW-1:0] ctrl_wa;
  logic [7:0]    ctrl_wd;

  logic [4:0]    lg_eff;
  logic [7:0]    cur_byte;
  logic [6:0]    fp;
  logic [AW:0]   cap;
  logic [63:0]   prod;
  logic [63:0]   hx;
  logic          out_free;

  always_comb begin
    lg_eff = (cap_lg_r < 4'd4) ? 5'd4 :
             ((5'(cap_lg_r) > LG_MAX) ? LG_MAX : 5'(cap_lg_r));
    cap = (AW+1)'(1) << lg_eff;
    cur_byte = key_r[8*byte_r[2:0] +: 8];
    hx = h_r ^ {56'd0, cur_byte};
    fp = h_r[6:0] & gphm_pkg::FP_MASK;
    prod = plo_r + {pmid_r[31:0], 32'd0} + {phi_r, 32'd0};
    // output register free to take the next result
    out_free = !ovalid_r || out_tready;
  end

  gphm_ram #(.WIDTH(8), .DEPTH(SLOTS)) u_ctrl (
    .clk(clk), .we(ctrl_we), .waddr(ctrl_wa), .wdata(ctrl_wd),
    .raddr(idx_r), .rdata(ctrl_rd));
  gphm_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_key (
    .clk(clk), .we(kv_we), .waddr(idx_r), .wdata(norm_r),
    .raddr(idx_r), .rdata(key_rd));
  gphm_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_val (
    .clk(clk), .we(kv_we), .waddr(idx_r), .wdata(val_r),
    .raddr(idx_r), .rdata(val_rd));

  logic slot_empty, slot_hit, grp_end;
  always_comb begin
    slot_empty = (ctrl_rd == gphm_pkg::CTRL_EMPTY);
    slot_hit = (act_r == gphm_pkg::ACT_LOOKUP) && !slot_empty &&
               (ctrl_rd == {1'b0, fp}) && (key_rd == norm_r);
    grp_end = (probed_r[3:0] == 4'hf);
    ctrl_we = 1'b0;
    kv_we = 1'b0;
    ctrl_wa = idx_r;
    ctrl_wd = {1'b0, fp};
    if (state_r == gphm_pkg::S_CLEAR) begin
      ctrl_we = 1'b1;
      ctrl_wa = clr_r;
      ctrl_wd = gphm_pkg::CTRL_EMPTY;
    end else if (state_r == gphm_pkg::S_CHK && slot_empty &&
                 act_r == gphm_pkg::ACT_INSERT) begin
      ctrl_we = 1'b1;
      kv_we = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gphm_pkg::S_CLEAR: if (clr_r == AW'(SLOTS - 1)) state_nxt = gphm_pkg::S_IDLE;
      gphm_pkg::S_IDLE:  if (in_tvalid) state_nxt = gphm_pkg::S_HASH;
      gphm_pkg::S_HASH:
        if (byte_r[3] || cur_byte == 8'd0) state_nxt = gphm_pkg::S_RD;
        else state_nxt = gphm_pkg::S_MUL;
      gphm_pkg::S_MUL:   state_nxt = gphm_pkg::S_HASH;
      gphm_pkg::S_RD:    state_nxt = gphm_pkg::S_CHK;
      gphm_pkg::S_CHK:
        if ((slot_empty && act_r == gphm_pkg::ACT_INSERT) || slot_hit ||
            (grp_end && (any_empty_r || slot_empty)) || (probed_r + 1'b1 == cap))
          state_nxt = gphm_pkg::S_OUT;
        else state_nxt = gphm_pkg::S_RD;
      gphm_pkg::S_OUT:   if (out_free) state_nxt = gphm_pkg::S_IDLE;
      default:           state_nxt = gphm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gphm_pkg::S_CLEAR;
      cap_lg_r <= 4'd10;
      clr_r <= '0;
      cnt_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) cap_lg_r <= cfg_wdata;
      if (state_r == gphm_pkg::S_OUT && out_free) ovalid_r <= 1'b1;
      else if (out_tvalid && out_tready) ovalid_r <= 1'b0;
      unique case (state_r)
        gphm_pkg::S_CLEAR: clr_r <= clr_r + 1'b1;
        gphm_pkg::S_IDLE: if (in_tvalid) begin
          act_r <= in_tuser;
          key_r <= in_tdata[63:0];
          val_r <= in_tdata[127:64];
          h_r <= gphm_pkg::FNV_OFFSET;
          norm_r <= '0;
          byte_r <= '0;
          mask_r <= AW'(cap - 1'b1);
        end
        gphm_pkg::S_HASH:
          if (byte_r[3] || cur_byte == 8'd0) begin
            idx_r <= h_r[AW-1:0] & mask_r;
            probed_r <= '0;
            any_empty_r <= 1'b0;
          end else begin
            norm_r[8*byte_r[2:0] +: 8] <= cur_byte;
            plo_r <= 64'(hx[31:0] * gphm_pkg::FNV_PRIME[31:0]);
            pmid_r <= 64'(hx[63:32] * gphm_pkg::FNV_PRIME[31:0]);
            phi_r <= 32'(hx[31:0] * gphm_pkg::FNV_PRIME[63:32]);
          end
        gphm_pkg::S_MUL: begin
          h_r <= prod;
          byte_r <= byte_r + 1'b1;
        end
        gphm_pkg::S_RD: ;
        gphm_pkg::S_CHK: begin
          probed_r <= probed_r + 1'b1;
          idx_r <= (idx_r + 1'b1) & mask_r;
          any_empty_r <= grp_end ? 1'b0 : (any_empty_r | slot_empty);
          vout_r <= '0;
          if (slot_empty && act_r == gphm_pkg::ACT_INSERT) begin
            st_r <= gphm_pkg::ST_OK;
            cnt_r <= cnt_r + 1'b1;
          end else if (slot_hit) begin
            st_r <= gphm_pkg::ST_OK;
            vout_r <= val_rd;
          end else if (act_r == gphm_pkg::ACT_INSERT) begin
            st_r <= gphm_pkg::ST_FULL;
          end else begin
            st_r <= gphm_pkg::ST_NOTFOUND;
          end
        end
        gphm_pkg::S_OUT: if (out_free) odata_r <= {3'd0, 11'(cnt_r), vout_r, st_r};
        default: ;
      endcase
    end
  end

  assign in_tready = (state_r == gphm_pkg::S_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata = odata_r;

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != gphm_pkg::S_IDLE) |-> !in_tready) else $error("ready while busy");
  a_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gphm_pkg::S_OUT && out_free) |=> out_tvalid) else $error("result lost");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != $past(cnt_r)) |-> ($past(kv_we))) else $error("count w/o insert");
  a_st: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (odata_r[1:0] != 2'd3)) else $error("bad status");

endmodule

### sv/gphm_ram.sv
module gphm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
